// File: src/csla_pkg.sv
package csla_pkg;

	localparam int TILE_SIZE_DEF  = 256;
	localparam int COORD_BITS_DEF = 28;

	// register indexes
	typedef enum logic [2:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_END_X   = 3'd2,
		REG_END_Y   = 3'd3,
		REG_RADIUS  = 3'd4,
		REG_RED     = 3'd5,
		REG_GREEN   = 3'd6,
		REG_BLUE    = 3'd7
	} reg_idx_t;

	localparam int CFG_DATA_W = COORD_BITS_DEF;
	localparam int CFG_IDX_W  = 3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

endpackage

// File: src/csla_if.sv
interface csla_in_if;
	logic        valid;
	logic        ready;
	logic [19:0] tile_x;
	logic [19:0] tile_y;
	logic [7:0]  col;
	logic [7:0]  row;
	modport source (output valid, tile_x, tile_y, col, row, input ready);
	modport sink   (input valid, tile_x, tile_y, col, row, output ready);
endinterface

interface csla_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] alpha;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	modport source (output valid, alpha, red, green, blue, input ready);
	modport sink   (input valid, alpha, red, green, blue, output ready);
endinterface

// File: src/capsule_sdf_line_alpha.sv
// channel  dir  payload                          transaction
// in       in   tile_x, tile_y, col, row         valid & ready
// out      out  alpha, red, green, blue          valid & ready
// cfg      in   cfg_we, cfg_idx, cfg_data        cfg_we high
//
// one pixel per cycle sustained while results are taken; the pipeline is the 16-stage
// projection divider, the 16-stage square root and eight more registers.
// arst_n clears all valid bits and sets the configuration registers to their reset values.
// the whole pipeline advances together; it halts only when the output
// register holds a result that is not taken.
module capsule_sdf_line_alpha
	import csla_pkg::*;
#(
	parameter int TILE_SIZE  = TILE_SIZE_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [COORD_BITS-1:0] cfg_data,
	csla_in_if.sink               in_ch,
	csla_out_if.source            out_ch
);
	localparam int CB   = COORD_BITS;
	localparam int DW   = CB + 1;            // signed difference
	localparam int PW   = 2 * DW + 2;        // dot / len2 width
	localparam int QW   = DW + 18;           // q16 offset width
	localparam int SQ_W = 32;                // (mx^2+my^2)>>16 < 2^27

	// configuration registers
	logic [CB-1:0] sx_q, sy_q, ex_q, ey_q;
	logic [3:0]    rad_q;
	color_t        col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0; sy_q <= '0; ex_q <= '0; ey_q <= '0;
			rad_q <= 4'd2;
			col_q <= '{red: 8'hff, green: 8'h00, blue: 8'h00};
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_START_X: sx_q <= CB'(cfg_data);
				REG_START_Y: sy_q <= CB'(cfg_data);
				REG_END_X:   ex_q <= CB'(cfg_data);
				REG_END_Y:   ey_q <= CB'(cfg_data);
				REG_RADIUS:  rad_q <= cfg_data[3:0];
				REG_RED:     col_q.red <= cfg_data[7:0];
				REG_GREEN:   col_q.green <= cfg_data[7:0];
				REG_BLUE:    col_q.blue <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// segment vector, constant between items
	logic signed [DW-1:0] bax, bay;
	assign bax = $signed({1'b0, ex_q}) - $signed({1'b0, sx_q});
	assign bay = $signed({1'b0, ey_q}) - $signed({1'b0, sy_q});

	logic signed [PW-1:0] len2_q;
	always_ff @(posedge clk) begin
		len2_q <= PW'(bax * bax) + PW'(bay * bay);
	end

	logic en;
	assign in_ch.ready = en;

	// s1: world position and offset from start
	logic s1_v;
	logic signed [DW-1:0] pax_s1, pay_s1;
	logic [CB-1:0] px, py;
	assign px = CB'(CB'(in_ch.tile_x) * CB'(TILE_SIZE) + CB'(in_ch.col));
	assign py = CB'(CB'(in_ch.tile_y) * CB'(TILE_SIZE) + CB'(in_ch.row));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s1_v <= 1'b0;
		else if (en) s1_v <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pax_s1 <= $signed({1'b0, px}) - $signed({1'b0, sx_q});
			pay_s1 <= $signed({1'b0, py}) - $signed({1'b0, sy_q});
		end
	end

	// s2: products for the dot product
	logic s2_v;
	logic signed [DW-1:0] pax_s2, pay_s2;
	logic signed [2*DW-1:0] ppx_s2, ppy_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s2_v <= 1'b0;
		else if (en) s2_v <= s1_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pax_s2 <= pax_s1; pay_s2 <= pay_s1;
			ppx_s2 <= pax_s1 * bax;
			ppy_s2 <= pay_s1 * bay;
		end
	end

	// s3: dot product and clamp decision
	logic s3_v;
	logic signed [DW-1:0] pax_s3, pay_s3;
	logic signed [PW-1:0] dot_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s3_v <= 1'b0;
		else if (en) s3_v <= s2_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pax_s3 <= pax_s2; pay_s3 <= pay_s2;
			dot_s3 <= PW'(ppx_s2) + PW'(ppy_s2);
		end
	end

	logic [1:0] hsel;   // 0 zero, 1 full, 2 divide
	always_comb begin
		if (dot_s3 <= 0) hsel = 2'd0;
		else if (dot_s3 >= len2_q) hsel = 2'd1;
		else hsel = 2'd2;
	end

	localparam int TAG_W = 2 * DW + 2;
	logic            dv_v;
	logic [15:0]     dv_q;
	logic [TAG_W-1:0] dv_tag;

	csla_div_pipe #(.DW(PW), .TAG_W(TAG_W)) u_div (
		.clk, .arst_n, .en,
		.in_valid (s3_v),
		.in_num   (dot_s3),
		.in_den   (len2_q),
		.in_tag   ({hsel, pax_s3, pay_s3}),
		.out_valid(dv_v),
		.out_quo  (dv_q),
		.out_tag  (dv_tag)
	);

	logic [1:0] hsel_d;
	logic signed [DW-1:0] pax_d, pay_d;
	assign {hsel_d, pax_d, pay_d} = dv_tag;
	logic [16:0] h;
	always_comb begin
		case (hsel_d)
			2'd0:    h = '0;
			2'd1:    h = 17'h10000;
			default: h = {1'b0, dv_q};
		endcase
	end

	// s4: offset products
	logic s4_v;
	logic signed [QW-1:0] bhx_s4, bhy_s4;
	logic signed [DW-1:0] pax_s4, pay_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s4_v <= 1'b0;
		else if (en) s4_v <= dv_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			bhx_s4 <= QW'(bax * $signed({1'b0, h}));
			bhy_s4 <= QW'(bay * $signed({1'b0, h}));
			pax_s4 <= pax_d; pay_s4 <= pay_d;
		end
	end

	// s5: magnitudes and far test
	logic s5_v, far_s5;
	logic [20:0] mx_s5, my_s5;
	logic signed [QW-1:0] dx, dy;
	logic [QW-1:0] amx, amy;
	assign dx = ($signed(QW'(pax_s4)) <<< 16) - bhx_s4;
	assign dy = ($signed(QW'(pay_s4)) <<< 16) - bhy_s4;
	assign amx = dx[QW-1] ? QW'(-dx) : QW'(dx);
	assign amy = dy[QW-1] ? QW'(-dy) : QW'(dy);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s5_v <= 1'b0;
		else if (en) s5_v <= s4_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			far_s5 <= (amx >= QW'(32'h200000)) || (amy >= QW'(32'h200000));
			mx_s5  <= amx[20:0];
			my_s5  <= amy[20:0];
		end
	end

	// s6: squares
	logic s6_v, far_s6;
	logic [41:0] sqx_s6, sqy_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s6_v <= 1'b0;
		else if (en) s6_v <= s5_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			far_s6 <= far_s5;
			sqx_s6 <= mx_s5 * mx_s5;
			sqy_s6 <= my_s5 * my_s5;
		end
	end

	// s7: sum of squares, scaled
	logic s7_v, far_s7;
	logic [SQ_W-1:0] ss_s7;
	logic [42:0] sum;
	assign sum = {1'b0, sqx_s6} + {1'b0, sqy_s6};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s7_v <= 1'b0;
		else if (en) s7_v <= s6_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			far_s7 <= far_s6;
			ss_s7  <= SQ_W'(sum[42:16]);
		end
	end

	logic        sq_v, far_r;
	logic [15:0] d8;
	csla_sqrt_pipe #(.IN_W(SQ_W), .TAG_W(1)) u_sqrt (
		.clk, .arst_n, .en,
		.in_valid (s7_v),
		.in_val   (ss_s7),
		.in_tag   (far_s7),
		.out_valid(sq_v),
		.out_root (d8),
		.out_tag  (far_r)
	);

	// s8: coverage and alpha into the output register
	logic signed [18:0] a;
	logic [7:0] alpha_n;
	logic [16:0] a255;
	assign a = 19'sd128 - $signed({3'b0, d8}) + $signed({7'b0, rad_q, 8'b0});
	assign a255 = 17'({a[8:0], 8'b0} - {8'b0, a[8:0]});
	always_comb begin
		if (far_r || a <= 0) alpha_n = 8'd0;
		else if (a >= 19'sd256) alpha_n = 8'd255;
		else alpha_n = a255[15:8];
	end

	logic o_v_q;
	assign en = !o_v_q || out_ch.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) o_v_q <= 1'b0;
		else if (en) o_v_q <= sq_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.alpha <= alpha_n;
			out_ch.red   <= col_q.red;
			out_ch.green <= col_q.green;
			out_ch.blue  <= col_q.blue;
		end
	end
	assign out_ch.valid = o_v_q;
endmodule

// File: src/csla_sqrt_pipe.sv
// pipelined integer square root, one result bit per stage, with stall enable
module csla_sqrt_pipe #(
	parameter int IN_W  = 32,
	parameter int TAG_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [IN_W-1:0]      in_val,
	input  logic [TAG_W-1:0]     in_tag,
	output logic                 out_valid,
	output logic [IN_W/2-1:0]    out_root,
	output logic [TAG_W-1:0]     out_tag
);
	localparam int N  = IN_W / 2;
	localparam int RW = N + 2;

	logic [N:0]         vld_q;
	logic [IN_W-1:0]    rad_q  [N+1];
	logic [RW-1:0]      rem_q  [N+1];
	logic [N-1:0]       root_q [N+1];
	logic [TAG_W-1:0]   tag_q  [N+1];

	always_comb begin
		rad_q[0]  = in_val;
		rem_q[0]  = '0;
		root_q[0] = '0;
		tag_q[0]  = in_tag;
		vld_q[0]  = in_valid;
	end

	// restoring digit recurrence, one bit per stage
	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] trial;
		logic          ok;
		always_comb begin
			rem_sh = {rem_q[i][RW-3:0], rad_q[i][IN_W-1 -: 2]};
			trial  = {root_q[i], 2'b01};
			ok     = rem_sh >= trial;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else if (en) begin
				vld_q[i+1] <= vld_q[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[i+1]  <= {rad_q[i][IN_W-3:0], 2'b00};
				rem_q[i+1]  <= ok ? rem_sh - trial : rem_sh;
				root_q[i+1] <= {root_q[i][N-2:0], ok};
				tag_q[i+1]  <= tag_q[i];
			end
		end
	end

	assign out_valid = vld_q[N];
	assign out_root  = root_q[N];
	assign out_tag   = tag_q[N];
endmodule

// File: src/csla_div_pipe.sv
// pipelined 16-bit quotient of num/den for num < den, one bit per stage
module csla_div_pipe #(
	parameter int DW    = 60,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [DW-1:0]    in_num,
	input  logic [DW-1:0]    in_den,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_valid,
	output logic [15:0]      out_quo,
	output logic [TAG_W-1:0] out_tag
);
	logic [16:0]      vld_q;
	logic [DW:0]      rem_q [17];
	logic [DW-1:0]    den_q [17];
	logic [15:0]      quo_q [17];
	logic [TAG_W-1:0] tag_q [17];

	always_comb begin
		vld_q[0] = in_valid;
		rem_q[0] = {1'b0, in_num};
		den_q[0] = in_den;
		quo_q[0] = '0;
		tag_q[0] = in_tag;
	end

	for (genvar i = 0; i < 16; i++) begin : g_stage
		logic [DW:0] sh;
		logic        ok;
		always_comb begin
			sh = {rem_q[i][DW-1:0], 1'b0};
			ok = sh >= {1'b0, den_q[i]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else if (en) begin
				vld_q[i+1] <= vld_q[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i+1] <= ok ? sh - {1'b0, den_q[i]} : sh;
				den_q[i+1] <= den_q[i];
				quo_q[i+1] <= {quo_q[i][14:0], ok};
				tag_q[i+1] <= tag_q[i];
			end
		end
	end

	assign out_valid = vld_q[16];
	assign out_quo   = quo_q[16];
	assign out_tag   = tag_q[16];
endmodule

// File: sim/tb_capsule_sdf_line_alpha.sv
module tb_capsule_sdf_line_alpha;
	timeunit 1ns;
	timeprecision 1ps;
	import csla_pkg::*;

	typedef struct packed {
		logic [19:0] tile_x;
		logic [19:0] tile_y;
		logic [7:0]  col;
		logic [7:0]  row;
	} pixel_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} shade_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	csla_in_if  in_ch ();
	csla_out_if out_ch ();

	capsule_sdf_line_alpha DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	// segment and color shadow
	logic [27:0] seg_ax, seg_ay, seg_bx, seg_by;
	logic [3:0]  radius;
	color_t      color;

	pixel_t pixel_q[$];
	shade_t shade_q[$];
	int     errors = 0;
	int     send_idle = 0;
	int     recv_idle = 0;
	bit     hold_off = 0;
	bit     hold_go = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("tb_capsule_sdf_line_alpha failed");
		$finish;
	end

	// long receiver hold-off, counted here once requested
	initial begin
		wait (hold_go);
		hold_off = 1;
		repeat (300) @(posedge clk);
		hold_off = 0;
	end

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// expected coverage of one pixel by the capsule
	function automatic shade_t predict_shade(pixel_t p);
		longint px, py, pax, pay, bax, bay, dot, dx, dy, a, h;
		longint unsigned len2, rem, mx, my, d8;
		shade_t s;
		px = longint'(({8'd0, p.tile_x} * 28'd256 + {20'd0, p.col}) & 28'hFFFFFFF);
		py = longint'(({8'd0, p.tile_y} * 28'd256 + {20'd0, p.row}) & 28'hFFFFFFF);
		pax = px - longint'(seg_ax);
		pay = py - longint'(seg_ay);
		bax = longint'(seg_bx) - longint'(seg_ax);
		bay = longint'(seg_by) - longint'(seg_ay);
		dot = pax * bax + pay * bay;
		len2 = longint'(bax * bax) + longint'(bay * bay);
		if (dot <= 0) begin
			h = 0;
		end else if (longint'(dot) >= len2) begin
			h = 65536;
		end else begin
			rem = dot;
			h = 0;
			for (int i = 0; i < 16; i++) begin
				rem = rem << 1;
				h = h << 1;
				if (rem >= len2) begin
					rem = rem - len2;
					h = h | 1;
				end
			end
		end
		dx = pax * 65536 - bax * h;
		dy = pay * 65536 - bay * h;
		mx = dx < 0 ? -dx : dx;
		my = dy < 0 ? -dy : dy;
		s.red = color.red;
		s.green = color.green;
		s.blue = color.blue;
		if (mx >= (64'd32 << 16) || my >= (64'd32 << 16)) begin
			s.alpha = 0;
		end else begin
			d8 = root64((mx * mx + my * my) >> 16);
			a = 128 - (longint'(d8) - longint'(radius) * 256);
			if (a <= 0) s.alpha = 0;
			else if (a >= 256) s.alpha = 255;
			else s.alpha = 8'((a * 255) >> 8);
		end
		return s;
	endfunction

	// driver: offer queued pixels, predict on each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.tile_x <= '0;
			in_ch.tile_y <= '0;
			in_ch.col <= '0;
			in_ch.row <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				shade_q.push_back(predict_shade({in_ch.tile_x, in_ch.tile_y,
					in_ch.col, in_ch.row}));
				void'(pixel_q.pop_front());
			end
			if (pixel_q.size() > (in_ch.valid && in_ch.ready ? 0 : 0) &&
			    !(in_ch.valid && in_ch.ready && pixel_q.size() == 0) &&
			    ($urandom_range(99) >= send_idle || (in_ch.valid && !in_ch.ready))) begin
				in_ch.valid <= 1'b1;
				{in_ch.tile_x, in_ch.tile_y, in_ch.col, in_ch.row} <= pixel_q[0];
			end else if (!(in_ch.valid && !in_ch.ready)) begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor: compare each result transaction with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		shade_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (shade_q.size() == 0) begin
					$error("unexpected result alpha %0d", out_ch.alpha);
					errors++;
				end else begin
					e = shade_q.pop_front();
					if (out_ch.alpha !== e.alpha) begin
						$error("alpha expected %0d actual %0d", e.alpha, out_ch.alpha);
						errors++;
					end
					if (out_ch.red !== e.red) begin
						$error("red expected %0d actual %0d", e.red, out_ch.red);
						errors++;
					end
					if (out_ch.green !== e.green) begin
						$error("green expected %0d actual %0d", e.green, out_ch.green);
						errors++;
					end
					if (out_ch.blue !== e.blue) begin
						$error("blue expected %0d actual %0d", e.blue, out_ch.blue);
						errors++;
					end
				end
			end
			out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [27:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_START_X: seg_ax = value;
			REG_START_Y: seg_ay = value;
			REG_END_X:   seg_bx = value;
			REG_END_Y:   seg_by = value;
			REG_RADIUS:  radius = value[3:0];
			REG_RED:     color.red = value[7:0];
			REG_GREEN:   color.green = value[7:0];
			REG_BLUE:    color.blue = value[7:0];
			default: ;
		endcase
	endtask

	task automatic drain_pipe();
		while (!(pixel_q.size() == 0 && !in_ch.valid && shade_q.size() == 0))
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_segment(logic [27:0] ax, logic [27:0] ay, logic [27:0] bx,
	                           logic [27:0] by, logic [3:0] r);
		write_reg(REG_START_X, ax);
		write_reg(REG_START_Y, ay);
		write_reg(REG_END_X, bx);
		write_reg(REG_END_Y, by);
		write_reg(REG_RADIUS, {24'd0, r});
	endtask

	// pixel near the segment with random jitter, else a random one
	task automatic queue_pixel(int near);
		pixel_t p;
		logic [27:0] wx, wy;
		int unsigned t;
		p = pixel_t'(56'({$urandom, $urandom}));
		if (near) begin
			t = $urandom_range(256);
			wx = 28'(longint'(seg_ax)
				+ ((longint'(seg_bx) - longint'(seg_ax)) * longint'(t)) / 256
				+ longint'($urandom_range(44)) - 22);
			wy = 28'(longint'(seg_ay)
				+ ((longint'(seg_by) - longint'(seg_ay)) * longint'(t)) / 256
				+ longint'($urandom_range(44)) - 22);
			p.tile_x = {wx[27:8]};
			p.tile_y = {wy[27:8]};
			p.col = wx[7:0];
			p.row = wy[7:0];
		end
		pixel_q.push_back(p);
	endtask

	initial begin
		logic [27:0] ax, ay;
		seg_ax = 0; seg_ay = 0; seg_bx = 0; seg_by = 0;
		radius = 2;
		color = '{red: 8'd255, green: 8'd0, blue: 8'd0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, zero-length segment at origin, extremes
		pixel_q.push_back('0);
		pixel_q.push_back({20'd0, 20'd0, 8'd1, 8'd1});
		pixel_q.push_back({20'd0, 20'd0, 8'd2, 8'd0});
		pixel_q.push_back({20'd0, 20'd0, 8'd31, 8'd0});
		pixel_q.push_back({20'd0, 20'd0, 8'd32, 8'd0});
		pixel_q.push_back({20'hFFFFF, 20'hFFFFF, 8'hFF, 8'hFF});
		pixel_q.push_back({20'hFFFFF, 20'd0, 8'hFF, 8'd0});
		drain_pipe();

		// world position wrap, maximum radius, extreme color
		set_segment(28'hFFFFFF0, 28'h0000010, 28'h0000010, 28'hFFFFFF0, 4'd15);
		write_reg(REG_RED, 28'd0);
		write_reg(REG_GREEN, 28'd255);
		write_reg(REG_BLUE, 28'd170);
		pixel_q.push_back({20'hFFFFF, 20'd0, 8'hF0, 8'h10});
		pixel_q.push_back({20'h0, 20'hFFFFF, 8'h10, 8'hF0});
		pixel_q.push_back({20'hFFFFF, 20'hFFFFF, 8'hFF, 8'hFF});
		pixel_q.push_back({20'h0, 20'h0, 8'h0, 8'h0});
		pixel_q.push_back({20'h00001, 20'h0, 8'h00, 8'h10});
		drain_pipe();

		// short horizontal segment, radius zero: start point, interior, beyond both ends
		set_segment(28'd1000, 28'd1000, 28'd1010, 28'd1000, 4'd0);
		write_reg(REG_RED, 28'd85);
		pixel_q.push_back({20'd3, 20'd3, 8'd232, 8'd232});
		pixel_q.push_back({20'd3, 20'd3, 8'd237, 8'd233});
		pixel_q.push_back({20'd3, 20'd3, 8'd240, 8'd232});
		pixel_q.push_back({20'd3, 20'd3, 8'd200, 8'd232});
		pixel_q.push_back({20'd3, 20'd3, 8'd250, 8'd232});
		drain_pipe();

		// random phases: each with a new segment, three idling profiles
		for (int ph = 0; ph < 17; ph++) begin
			send_idle = ph < 6 ? 9 : (ph < 12 ? 86 : 0);
			recv_idle = ph < 6 ? 86 : (ph < 12 ? 9 : 0);
			ax = 28'($urandom);
			ay = 28'($urandom);
			if (ph % 4 == 3)
				set_segment(ax, ay, ax, ay, 4'($urandom));
			else
				set_segment(ax, ay, 28'(ax + $urandom_range(200) - 100),
					28'(ay + $urandom_range(200) - 100), 4'($urandom));
			write_reg(REG_RED, 28'($urandom));
			write_reg(REG_GREEN, 28'($urandom));
			write_reg(REG_BLUE, 28'($urandom));
			for (int i = 0; i < 50; i++) queue_pixel($urandom_range(9) < 8);
			// long receiver hold-off while the sender keeps offering
			if (ph == 14) hold_go = 1;
			drain_pipe();
		end

		if (errors == 0)
			$display("tb_capsule_sdf_line_alpha passed");
		else
			$display("tb_capsule_sdf_line_alpha failed");
		$finish;
	end

endmodule

// File: capsule_sdf_line_alpha.f
src/csla_pkg.sv
src/csla_if.sv
src/csla_sqrt_pipe.sv
src/csla_div_pipe.sv
src/capsule_sdf_line_alpha.sv
sim/tb_capsule_sdf_line_alpha.sv
